// ===== rtl/sapq_pkg.sv =====
// shared constants, codes and types of the sorted-array priority queue
package sapq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int VALUE_W     = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd4;

    typedef logic signed [VALUE_W-1:0] value_t;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    // per-cell control from the sequencer
    typedef struct packed {
        cell_op_t op;
        logic     occupied;
        logic     tail;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

endpackage

// ===== rtl/sapq_req_if.sv =====
// request channel: request code and value
interface sapq_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [sapq_pkg::REQ_W-1:0]              req_type;
    logic signed [sapq_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

// ===== rtl/sapq_res_if.sv =====
// result channel: status, listed value and last marker
interface sapq_res_if;
    logic                                    valid;
    logic                                    ready;
    logic [sapq_pkg::STATUS_W-1:0]           status;
    logic signed [sapq_pkg::VALUE_W-1:0]     entry_value;
    logic                                    last;

    modport source (output valid, output status, output entry_value, output last,
                    input ready);
    modport sink (input valid, input status, input entry_value, input last,
                  output ready);
endinterface

// ===== rtl/sorted_array_priority_queue.sv =====
// top level of the sorted-array priority queue: cell row and request sequencer
//
// Usage: requests arrive on req (req_type, value), results leave on res
// (status, entry_value, last), both valid/ready, an item moves when both
// are high. Entries are held in descending order in a row of QUEUE_DEPTH
// cells that compare with the request value and shift in parallel.
// Insert and delete: the cells update on the accepting edge
// and the single result (last = 1) is valid in the next cycle.
// A list request rotates the occupied cells one place per cycle while results
// are taken and sends the head cell out, so it gives occupancy results, one
// per such cycle, the last one marked; an empty queue gives one empty status instead.
// Throughput: one insert or delete per cycle while the receiver takes
// results; a list holds off new requests until its last result leaves.
// The result register holds its item while res.ready is low; no request is
// taken and no listing step is made until that item leaves.
// Request code 3 is accepted and dropped without a result.
// Reset clears the occupancy count, the sequencer and the result valid;
// entry contents are not cleared and are never read before written.
module sorted_array_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    sapq_req_if.sink    req,
    sapq_res_if.source  res
);
    import sapq_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    value_t                value_reg, value_next;
    logic                  last_reg, last_next;

    cell_op_t              op;
    cell_ctrl_t            ctrl [QUEUE_DEPTH];
    value_t                entry_w [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]  take_chain;
    logic [QUEUE_DEPTH:0]  seen_chain;

    logic out_free;
    logic accept;
    logic full;
    logic empty;
    logic found;
    logic list_last;

    assign out_free  = !res_valid_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (occ_reg == '0);
    assign found     = seen_chain[QUEUE_DEPTH];
    assign list_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg);

    assign take_chain[0] = 1'b0;
    assign seen_chain[0] = 1'b0;

    // row of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        value_t left_entry;
        value_t right_entry;

        assign ctrl[i].op       = op;
        assign ctrl[i].occupied = (CNT_W'(i) < occ_reg);
        assign ctrl[i].tail     = (CNT_W'(i + 1) == occ_reg);

        if (i == 0)
        begin : g_head
            assign left_entry = req.value;
        end
        else
        begin : g_body
            assign left_entry = entry_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_end
            assign right_entry = entry_w[i];
        end
        else
        begin : g_mid
            assign right_entry = entry_w[i+1];
        end

        sapq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl[i]),
            .key         (req.value),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .wrap_entry  (entry_w[0]),
            .left_take   (take_chain[i]),
            .left_seen   (seen_chain[i]),
            .entry       (entry_w[i]),
            .take        (take_chain[i+1]),
            .seen        (seen_chain[i+1])
        );
    end

    // sequencer: request decode, listing steps and result register load
    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        op             = CELL_HOLD;
        res_valid_next = res_valid_reg && !res.ready;
        status_next    = status_reg;
        value_next     = value_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_INSERT:
                        begin
                            res_valid_next = 1'b1;
                            value_next     = '0;
                            last_next      = 1'b1;
                            if (full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                status_next = ST_DONE;
                                op          = CELL_INSERT;
                                occ_next    = occ_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            res_valid_next = 1'b1;
                            value_next     = '0;
                            last_next      = 1'b1;
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (found)
                            begin
                                status_next = ST_DONE;
                                op          = CELL_DELETE;
                                occ_next    = occ_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        REQ_LIST:
                        begin
                            if (empty)
                            begin
                                res_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                                value_next     = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LIST;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            op = CELL_HOLD;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_LISTED;
                    value_next     = entry_w[0];
                    last_next      = list_last;
                    op             = CELL_ROTATE;
                    idx_next       = idx_reg + IDX_W'(1);
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    assign res.valid       = res_valid_reg;
    assign res.status      = status_reg;
    assign res.entry_value = value_reg;
    assign res.last        = last_reg;

endmodule

// ===== rtl/sapq_cell.sv =====
// one queue cell: holds one entry, compares with the key and shifts with its neighbors
module sapq_cell (
    input  logic                 clk,
    input  sapq_pkg::cell_ctrl_t ctrl,
    input  sapq_pkg::value_t     key,
    input  sapq_pkg::value_t     left_entry,
    input  sapq_pkg::value_t     right_entry,
    input  sapq_pkg::value_t     wrap_entry,
    input  logic                 left_take,
    input  logic                 left_seen,
    output sapq_pkg::value_t     entry,
    output logic                 take,
    output logic                 seen
);
    import sapq_pkg::*;

    value_t entry_reg;
    value_t entry_next;
    logic   match;

    // insert point: free cell or key not below the stored entry
    assign take  = !ctrl.occupied || (key >= entry_reg);
    // delete point: running flag of the first equal entry
    assign match = ctrl.occupied && (entry_reg == key);
    assign seen  = left_seen || match;
    assign entry = entry_reg;

    // next entry
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_INSERT:
            begin
                if (take)
                begin
                    entry_next = left_take ? left_entry : key;
                end
            end
            CELL_DELETE:
            begin
                if (seen)
                begin
                    entry_next = right_entry;
                end
            end
            CELL_ROTATE:
            begin
                entry_next = ctrl.tail ? wrap_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/sapq_checker.sv =====
// port-level checks of the priority queue, bound to the top level
module sapq_assertions (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [sapq_pkg::STATUS_W-1:0]   res_status,
    input sapq_pkg::value_t                res_entry_value,
    input logic                            res_last
);
    import sapq_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_status) && $stable(res_entry_value)
            && $stable(res_last))
        else $error("result item changed while stalled");

    // no result is offered while in reset
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // only listed entries carry a value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != ST_LISTED) |-> (res_entry_value == '0))
        else $error("status item with nonzero value");

    // every status item ends its request
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != ST_LISTED) |-> res_last)
        else $error("status item without last");

endmodule

bind sorted_array_priority_queue sapq_assertions u_sapq_assertions (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_entry_value (res.entry_value),
    .res_last        (res.last)
);
